>>> design/dtpl_pkg.sv
// Package for the decimating track point logger.
// Holds the shared widths, reset constants, request codes and sequencer states.
`default_nettype none
package dtpl_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int COORD_W       = 24;
    localparam int SQ_W          = 2 * COORD_W;
    localparam int STEP_W        = 50;
    localparam int IDX_W         = 10;
    localparam int COUNT_OUT_W   = 9;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(82944);

    typedef enum logic [1:0] {
        REQ_RECORD = 2'd0,
        REQ_READ   = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SQY,
        S_SUM,
        S_CMP,
        S_STORE,
        S_RDATA
    } t_state;

endpackage
`default_nettype wire

>>> design/dtpl_sqr.sv
// Squared difference unit of the track point logger: |a - b| squared, registered.
// Depends on dtpl_pkg for the coordinate width.
`default_nettype none
module dtpl_sqr (
    input  wire logic                                  i_clk,
    input  wire logic signed [dtpl_pkg::COORD_W-1:0]   i_a,
    input  wire logic signed [dtpl_pkg::COORD_W-1:0]   i_b,
    output logic             [dtpl_pkg::SQ_W-1:0]      o_sq
);

    logic signed [dtpl_pkg::COORD_W:0] w_diff;
    logic signed [dtpl_pkg::COORD_W:0] w_neg;
    logic        [dtpl_pkg::COORD_W-1:0] w_mag;
    logic        [dtpl_pkg::SQ_W-1:0] r_sq;

    assign w_diff = (dtpl_pkg::COORD_W+1)'(i_a) - (dtpl_pkg::COORD_W+1)'(i_b);
    assign w_neg  = -w_diff;
    assign w_mag  = w_diff[dtpl_pkg::COORD_W] ? w_neg[dtpl_pkg::COORD_W-1:0]
                                               : w_diff[dtpl_pkg::COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        r_sq <= dtpl_pkg::SQ_W'(w_mag) * dtpl_pkg::SQ_W'(w_mag);
    end

    assign o_sq = r_sq;

endmodule
`default_nettype wire

>>> design/decimating_track_point_logger.sv
// Top level of the decimating track point logger: sequencer, ring store and registers.
// Depends on dtpl_pkg and the squared difference unit dtpl_sqr.
//
// An item is taken when start is high and busy is low; its single result appears on the
// o_ ports for one cycle with o_done high, and the receiver cannot stall it. A record
// request passes through EXEC, SQY, SUM, CMP and STORE when the store holds points
// (ending in CMP when the point is rejected), since x and y pass in turn through one
// registered squaring multiplier and the sum is compared in a later state; into an
// empty store it goes from EXEC to STORE. A valid read passes through EXEC and RDATA
// via the registered read port of the single-port store; an out-of-range read, a clear
// and an unused code end in EXEC. The next item can be taken while the result is shown.
`default_nettype none
module decimating_track_point_logger #(
    parameter int DEPTH = dtpl_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     start,
    output logic                                          busy,
    input  wire logic                                     i_cfg_we,
    input  wire logic        [dtpl_pkg::STEP_W-1:0]       i_cfg_wdata,
    input  wire logic        [1:0]                        i_req_type,
    input  wire logic signed [dtpl_pkg::COORD_W-1:0]      i_pos_x,
    input  wire logic signed [dtpl_pkg::COORD_W-1:0]      i_pos_y,
    input  wire logic        [dtpl_pkg::IDX_W-1:0]        i_read_index,
    output logic                                          o_done,
    output logic signed [dtpl_pkg::COORD_W-1:0]           o_point_x,
    output logic signed [dtpl_pkg::COORD_W-1:0]           o_point_y,
    output logic                                          o_entry_valid,
    output logic                                          o_point_stored,
    output logic        [dtpl_pkg::COUNT_OUT_W-1:0]       o_stored_count
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > dtpl_pkg::IDX_W) ? CW : dtpl_pkg::IDX_W;
    localparam int SW   = CMPW + 1;
    localparam int XW   = dtpl_pkg::COORD_W;

    dtpl_pkg::t_state r_state, n_state;
    dtpl_pkg::t_req   r_req, n_req;

    logic signed [XW-1:0] r_px, n_px, r_py, n_py;
    logic [dtpl_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_oldest, n_oldest;
    logic signed [XW-1:0] r_newest_x, n_newest_x, r_newest_y, n_newest_y;
    logic [dtpl_pkg::STEP_W-1:0] r_min_step;
    logic [dtpl_pkg::STEP_W-1:0] r_acc, n_acc;

    logic r_done, n_done;
    logic signed [XW-1:0] r_out_x, n_out_x, r_out_y, n_out_y;
    logic r_valid, n_valid, r_stored, n_stored;
    logic [dtpl_pkg::COUNT_OUT_W-1:0] r_out_count, n_out_count;

    logic [2*XW-1:0] mem [DEPTH];
    logic [2*XW-1:0] r_rdata;
    logic            mem_we, mem_re;
    logic [PW-1:0]   mem_addr;
    logic [2*XW-1:0] mem_wdata;

    logic signed [XW-1:0] w_op_a, w_op_b;
    logic [dtpl_pkg::SQ_W-1:0] w_sq;
    logic [CMPW-1:0] w_off;
    logic [SW-1:0]   w_sum;
    logic [PW-1:0]   w_slot;
    logic            w_full;
    logic            w_accept;
    logic            w_rd_ok;
    logic [CMPW-1:0] w_count_ext;
    logic [CMPW-1:0] w_count_inc_ext;
    logic [CW-1:0]   w_count_inc;

    assign busy     = (r_state != dtpl_pkg::S_IDLE);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_rd_ok  = (CMPW'(r_idx) < CMPW'(r_count));

    assign w_off  = (r_state == dtpl_pkg::S_EXEC) ? CMPW'(r_idx) : CMPW'(r_count);
    assign w_sum  = SW'(r_oldest) + SW'(w_off);
    assign w_slot = (w_sum >= SW'(DEPTH)) ? PW'(w_sum - SW'(DEPTH)) : PW'(w_sum);

    assign w_count_inc     = r_count + CW'(1);
    assign w_count_ext     = CMPW'(r_count);
    assign w_count_inc_ext = CMPW'(w_count_inc);

    assign w_op_a = (r_state == dtpl_pkg::S_EXEC) ? r_px : r_py;
    assign w_op_b = (r_state == dtpl_pkg::S_EXEC) ? r_newest_x : r_newest_y;

    dtpl_sqr u_sqr (
        .i_clk (i_clk),
        .i_a   (w_op_a),
        .i_b   (w_op_b),
        .o_sq  (w_sq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtpl_pkg::S_IDLE;
            r_count     <= '0;
            r_oldest    <= '0;
            r_newest_x  <= '0;
            r_newest_y  <= '0;
            r_min_step  <= dtpl_pkg::STEP_RESET;
            r_done      <= 1'b0;
            r_valid     <= 1'b0;
            r_stored    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_oldest    <= n_oldest;
            r_newest_x  <= n_newest_x;
            r_newest_y  <= n_newest_y;
            if (i_cfg_we) begin
                r_min_step <= i_cfg_wdata;
            end
            r_done      <= n_done;
            r_valid     <= n_valid;
            r_stored    <= n_stored;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_px        <= n_px;
        r_py        <= n_py;
        r_idx       <= n_idx;
        r_acc       <= n_acc;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_count <= n_out_count;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_px        = r_px;
        n_py        = r_py;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_count     = r_count;
        n_oldest    = r_oldest;
        n_newest_x  = r_newest_x;
        n_newest_y  = r_newest_y;
        n_done      = 1'b0;
        n_out_x     = '0;
        n_out_y     = '0;
        n_valid     = 1'b0;
        n_stored    = 1'b0;
        n_out_count = r_out_count;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = w_slot;
        mem_wdata   = {r_px, r_py};

        unique case (r_state)
            dtpl_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_req   = dtpl_pkg::t_req'(i_req_type);
                    n_px    = i_pos_x;
                    n_py    = i_pos_y;
                    n_idx   = i_read_index;
                    n_state = dtpl_pkg::S_EXEC;
                end
            end
            dtpl_pkg::S_EXEC: begin
                unique case (r_req)
                    dtpl_pkg::REQ_RECORD: begin
                        n_state = (r_count == '0) ? dtpl_pkg::S_STORE : dtpl_pkg::S_SQY;
                    end
                    dtpl_pkg::REQ_READ: begin
                        if (w_rd_ok) begin
                            mem_re  = 1'b1;
                            n_state = dtpl_pkg::S_RDATA;
                        end else begin
                            n_done      = 1'b1;
                            n_out_count = w_count_ext[dtpl_pkg::COUNT_OUT_W-1:0];
                            n_state     = dtpl_pkg::S_IDLE;
                        end
                    end
                    dtpl_pkg::REQ_CLEAR: begin
                        n_count     = '0;
                        n_oldest    = '0;
                        n_newest_x  = '0;
                        n_newest_y  = '0;
                        n_done      = 1'b1;
                        n_out_count = '0;
                        n_state     = dtpl_pkg::S_IDLE;
                    end
                    dtpl_pkg::REQ_NONE: begin
                        n_done      = 1'b1;
                        n_out_count = w_count_ext[dtpl_pkg::COUNT_OUT_W-1:0];
                        n_state     = dtpl_pkg::S_IDLE;
                    end
                endcase
            end
            dtpl_pkg::S_SQY: begin
                n_acc   = dtpl_pkg::STEP_W'(w_sq);
                n_state = dtpl_pkg::S_SUM;
            end
            dtpl_pkg::S_SUM: begin
                n_acc   = r_acc + dtpl_pkg::STEP_W'(w_sq);
                n_state = dtpl_pkg::S_CMP;
            end
            dtpl_pkg::S_CMP: begin
                if (r_acc >= r_min_step) begin
                    n_state = dtpl_pkg::S_STORE;
                end else begin
                    n_done      = 1'b1;
                    n_out_count = w_count_ext[dtpl_pkg::COUNT_OUT_W-1:0];
                    n_state     = dtpl_pkg::S_IDLE;
                end
            end
            dtpl_pkg::S_STORE: begin
                mem_we     = 1'b1;
                n_newest_x = r_px;
                n_newest_y = r_py;
                n_stored   = 1'b1;
                n_done     = 1'b1;
                if (w_full) begin
                    mem_addr    = r_oldest;
                    n_oldest    = (r_oldest == PW'(DEPTH - 1)) ? '0 : r_oldest + PW'(1);
                    n_out_count = w_count_ext[dtpl_pkg::COUNT_OUT_W-1:0];
                end else begin
                    n_count     = w_count_inc;
                    n_out_count = w_count_inc_ext[dtpl_pkg::COUNT_OUT_W-1:0];
                end
                n_state = dtpl_pkg::S_IDLE;
            end
            dtpl_pkg::S_RDATA: begin
                n_out_x     = r_rdata[2*XW-1:XW];
                n_out_y     = r_rdata[XW-1:0];
                n_valid     = 1'b1;
                n_done      = 1'b1;
                n_out_count = w_count_ext[dtpl_pkg::COUNT_OUT_W-1:0];
                n_state     = dtpl_pkg::S_IDLE;
            end
            default: begin
                n_state = dtpl_pkg::S_IDLE;
            end
        endcase
    end

    assign o_done         = r_done;
    assign o_point_x      = r_out_x;
    assign o_point_y      = r_out_y;
    assign o_entry_valid  = r_valid;
    assign o_point_stored = r_stored;
    assign o_stored_count = r_out_count;

    // The ring pointer only moves once the store is full.
    a_oldest_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oldest != '0) |-> w_full)
        else $error("ring pointer moved while store not full");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(DEPTH)))
        else $error("point count above depth");

    a_flags_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_entry_valid || o_point_stored) |-> o_done)
        else $error("result flag set without result strobe");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while sequencer still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start the sequencer");

endmodule
`default_nettype wire

>>> tb/sv/track_log_checker.sv
// Checker for the decimating track point logger: predicts each result and compares it.
// Depends on dtpl_pkg; it watches the request, configuration and result ports.
`default_nettype none
module track_log_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic                                i_busy,
    input  wire logic                                i_cfg_we,
    input  wire logic        [dtpl_pkg::STEP_W-1:0]  i_cfg_wdata,
    input  wire logic        [1:0]                   i_req_type,
    input  wire logic signed [dtpl_pkg::COORD_W-1:0] i_pos_x,
    input  wire logic signed [dtpl_pkg::COORD_W-1:0] i_pos_y,
    input  wire logic        [dtpl_pkg::IDX_W-1:0]   i_read_index,
    input  wire logic                                i_done,
    input  wire logic signed [dtpl_pkg::COORD_W-1:0] i_point_x,
    input  wire logic signed [dtpl_pkg::COORD_W-1:0] i_point_y,
    input  wire logic                                i_entry_valid,
    input  wire logic                                i_point_stored,
    input  wire logic   [dtpl_pkg::COUNT_OUT_W-1:0]  i_stored_count,
    output int                                       o_fail_count,
    output int                                       o_pending
);
    import dtpl_pkg::*;

    localparam int RING_DEPTH = DEPTH_DEFAULT;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      valid;
        logic                      stored;
        logic [COUNT_OUT_W-1:0]    count;
    } t_track_result;

    logic signed [COORD_W-1:0] ring_x [RING_DEPTH];
    logic signed [COORD_W-1:0] ring_y [RING_DEPTH];
    logic signed [COORD_W-1:0] newest_x;
    logic signed [COORD_W-1:0] newest_y;
    logic [STEP_W-1:0]         min_step;
    int                        oldest;
    int                        held;
    int                        mismatches;
    t_track_result             expected_results [$];

    function automatic t_track_result log_request(input logic [1:0] req,
            input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
            input logic [IDX_W-1:0] idx);
        t_track_result res;
        longint dx;
        longint dy;
        longint unsigned dist_sq;
        int slot;
        res = '0;
        dx = longint'(x) - longint'(newest_x);
        dy = longint'(y) - longint'(newest_y);
        dist_sq = $unsigned(dx * dx + dy * dy);
        case (req)
            REQ_RECORD: begin
                if (held == 0 || dist_sq >= 64'(min_step)) begin
                    if (held < RING_DEPTH) begin
                        slot = (oldest + held) % RING_DEPTH;
                        held++;
                    end else begin
                        slot = oldest;
                        oldest = (oldest + 1) % RING_DEPTH;
                    end
                    ring_x[slot] = x;
                    ring_y[slot] = y;
                    newest_x = x;
                    newest_y = y;
                    res.stored = 1'b1;
                end
            end
            REQ_READ: begin
                if (int'(idx) < held) begin
                    slot = (oldest + int'(idx)) % RING_DEPTH;
                    res.x = ring_x[slot];
                    res.y = ring_y[slot];
                    res.valid = 1'b1;
                end
            end
            REQ_CLEAR: begin
                held = 0;
                oldest = 0;
                newest_x = '0;
                newest_y = '0;
            end
            default: ;
        endcase
        res.count = COUNT_OUT_W'(held);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_track_result got;
        t_track_result want;
        if (!i_rst_n) begin
            held = 0;
            oldest = 0;
            newest_x = '0;
            newest_y = '0;
            min_step = STEP_RESET;
            expected_results.delete();
        end else begin
            if (i_done) begin
                got = '{i_point_x, i_point_y, i_entry_valid, i_point_stored, i_stored_count};
                if (expected_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected result x=%0d y=%0d valid=%0b stored=%0b count=%0d",
                                 $time, got.x, got.y, got.valid, got.stored, got.count);
                    end
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        if (mismatches < 10) begin
                            $display("%0t: expected x=%0d y=%0d valid=%0b stored=%0b count=%0d",
                                     $time, want.x, want.y, want.valid, want.stored, want.count);
                            $display("%0t: actual   x=%0d y=%0d valid=%0b stored=%0b count=%0d",
                                     $time, got.x, got.y, got.valid, got.stored, got.count);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                min_step = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                expected_results.push_back(log_request(i_req_type, i_pos_x, i_pos_y,
                                                       i_read_index));
            end
        end
        o_fail_count <= mismatches;
        o_pending <= expected_results.size();
    end

endmodule
`default_nettype wire

>>> tb/sv/tb_decimating_track_point_logger.sv
// Testbench top for the decimating track point logger: clock, reset, requests and verdict.
// Depends on dtpl_pkg, the block itself and track_log_checker.
`default_nettype none
module tb_decimating_track_point_logger;
    import dtpl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic signed [COORD_W-1:0] X_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] X_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [STEP_W-1:0] STEP_ZERO = {STEP_W{1'b0}};
    localparam logic [STEP_W-1:0] STEP_ALL = {STEP_W{1'b1}};

    logic                      i_clk;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      cfg_we = 1'b0;
    logic [STEP_W-1:0]         cfg_wdata = '0;
    logic [1:0]                req_type = REQ_RECORD;
    logic signed [COORD_W-1:0] pos_x = '0;
    logic signed [COORD_W-1:0] pos_y = '0;
    logic [IDX_W-1:0]          read_index = '0;
    logic                      done;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      entry_valid;
    logic                      point_stored;
    logic [COUNT_OUT_W-1:0]    stored_count;
    int                        fail_count;
    int                        pending;
    int                        cycle_count = 0;
    logic signed [COORD_W-1:0] last_x = '0;
    logic signed [COORD_W-1:0] last_y = '0;

    decimating_track_point_logger u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_req_type     (req_type),
        .i_pos_x        (pos_x),
        .i_pos_y        (pos_y),
        .i_read_index   (read_index),
        .o_done         (done),
        .o_point_x      (point_x),
        .o_point_y      (point_y),
        .o_entry_valid  (entry_valid),
        .o_point_stored (point_stored),
        .o_stored_count (stored_count)
    );

    track_log_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_req_type     (req_type),
        .i_pos_x        (pos_x),
        .i_pos_y        (pos_y),
        .i_read_index   (read_index),
        .i_done         (done),
        .i_point_x      (point_x),
        .i_point_y      (point_y),
        .i_entry_valid  (entry_valid),
        .i_point_stored (point_stored),
        .i_stored_count (stored_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic issue_request(input logic [1:0] req, input logic signed [COORD_W-1:0] x,
            input logic signed [COORD_W-1:0] y, input logic [IDX_W-1:0] idx,
            input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        req_type <= req;
        pos_x <= x;
        pos_y <= y;
        read_index <= idx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (req == REQ_RECORD) begin
            last_x = x;
            last_y = y;
        end
    endtask

    task automatic set_min_step(input logic [STEP_W-1:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_request(input int idle_pct, input bit allow_clear);
        int pick;
        logic [1:0] req;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(0, 999);
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
        idx = IDX_W'($urandom);
        if (pick < 640) begin
            req = REQ_RECORD;
            if ($urandom_range(0, 1) == 1) begin
                // Moves around the default threshold so both outcomes occur often.
                x = last_x + COORD_W'(int'($urandom_range(0, 800)) - 400);
                y = last_y + COORD_W'(int'($urandom_range(0, 800)) - 400);
            end
        end else if (pick < 960) begin
            req = REQ_READ;
            if ($urandom_range(0, 9) < 7) begin
                idx = IDX_W'($urandom_range(0, 256));
            end
        end else if (pick < 995 || !allow_clear) begin
            req = REQ_NONE;
        end else begin
            req = REQ_CLEAR;
        end
        issue_request(req, x, y, idx, idle_pct);
    endtask

    initial begin
        logic [STEP_W-1:0] phase_step [6];
        int phase_items [6];
        int issued;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue_request(REQ_READ, '0, '0, '0, 24);
        issue_request(REQ_RECORD, '0, '0, '0, 24);
        issue_request(REQ_RECORD, 24'sd287, '0, '0, 24);
        issue_request(REQ_RECORD, 24'sd288, '0, '0, 24);
        issue_request(REQ_RECORD, X_MAX, X_MIN, '0, 24);
        issue_request(REQ_RECORD, X_MIN, X_MAX, '0, 24);
        issue_request(REQ_RECORD, X_MIN, X_MAX, '0, 24);
        issue_request(REQ_READ, '0, '0, 10'd0, 24);
        issue_request(REQ_READ, '0, '0, 10'd3, 24);
        issue_request(REQ_READ, '0, '0, 10'd4, 24);
        issue_request(REQ_READ, '0, '0, 10'd1023, 24);
        issue_request(REQ_NONE, X_MAX, X_MIN, 10'd1023, 24);
        issue_request(REQ_CLEAR, X_MIN, X_MAX, 10'd512, 24);
        issue_request(REQ_READ, '0, '0, 10'd0, 24);
        issue_request(REQ_RECORD, 24'sd1, 24'sd1, '0, 24);
        set_min_step(STEP_ZERO);
        issue_request(REQ_RECORD, 24'sd1, 24'sd1, '0, 24);
        issue_request(REQ_READ, '0, '0, 10'd1, 24);
        set_min_step(STEP_ALL);
        issue_request(REQ_RECORD, X_MAX, X_MAX, '0, 24);
        issue_request(REQ_RECORD, X_MIN, X_MIN, '0, 24);
        issue_request(REQ_READ, '0, '0, 10'd0, 24);
        issue_request(REQ_CLEAR, '0, '0, '0, 24);
        issue_request(REQ_RECORD, X_MIN, X_MIN, '0, 24);

        phase_step = '{STEP_ZERO, STEP_RESET, STEP_W'(4096),
                       STEP_W'($urandom_range(1, 1 << 20)), STEP_ALL, STEP_W'(1)};
        phase_items = '{400, 300, 300, 250, 100, 250};
        issued = 0;
        for (int p = 0; p < 6; p++) begin
            set_min_step(phase_step[p]);
            for (int k = 0; k < phase_items[p]; k++) begin
                random_request(issued < 533 ? 24 : (issued < 1066 ? 84 : 0), p >= 2);
                issued++;
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> decimating_track_point_logger.f
design/dtpl_pkg.sv
design/dtpl_sqr.sv
design/decimating_track_point_logger.sv
tb/sv/track_log_checker.sv
tb/sv/tb_decimating_track_point_logger.sv
